>>> design/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants for the five-level priority queue core.
// ----------------------------------------------------------------------------
package fpq_pkg;

	localparam int unsigned LEVELS_DEF      = 5;
	localparam int unsigned LEVEL_DEPTH_DEF = 16;
	localparam int unsigned SENDER_BITS_DEF = 8;
	localparam int unsigned PAYLOAD_BITS_DEF = 16;

	localparam int unsigned CMD_BITS    = 2;
	localparam int unsigned RANK_BITS   = 3;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned COUNT_BITS  = 7;
	localparam int unsigned COUNT_MAX   = 127;
	localparam int unsigned OUT_SENDER_BITS  = 8;
	localparam int unsigned OUT_PAYLOAD_BITS = 16;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SEND     = 2'd0,
		CMD_ANNOUNCE = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_PROMOTE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE      = 2'd0,
		ST_ANNOUNCED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_DROPPED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SCAN,
		S_NEXT,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture input fields
		logic do_send;   // append to a level
		logic scan_init; // set up walk of current level
		logic scan_rd;   // issue read of slot
		logic scan_step; // consume read data, drop, move or keep entry
		logic scan_end;  // close current level
		logic lvl_next;  // go to next lower level
		logic finish;    // raise result strobe
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_send;
		logic level_done;  // read pointer at fill
		logic last_level;  // no level below current, or announce served
	} sts_t;

endpackage

>>> design/fpq_ctrl.sv
// ----------------------------------------------------------------------------
// fpq_ctrl
// Sequencer for the priority queue: decodes the command and, for all but send,
// steps the datapath through the levels, one stored entry per READ/SCAN pair.
// ----------------------------------------------------------------------------
module fpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fpq_pkg::sts_t sts,
	output fpq_pkg::ctl_t ctl
);
	import fpq_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (start) state_d = S_DECODE;
			S_DECODE: begin
				if (sts.is_send) state_d = S_DONE;
				else state_d = S_READ;
			end
			S_READ: begin
				if (sts.level_done) state_d = S_NEXT;
				else state_d = S_SCAN;
			end
			S_SCAN:   state_d = S_READ;
			S_NEXT: begin
				if (sts.last_level) state_d = S_DONE;
				else state_d = S_READ;
			end
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:   ctl.latch = start;
			S_DECODE: begin
				ctl.do_send = sts.is_send;
				ctl.scan_init = !sts.is_send;
			end
			S_READ: begin
				ctl.scan_rd = !sts.level_done;
				ctl.scan_end = sts.level_done;
			end
			S_SCAN:   ctl.scan_step = 1'b1;
			S_NEXT: begin
				ctl.lvl_next = !sts.last_level;
			end
			S_DONE:   ctl.finish = 1'b1;
			default:  ctl = '0;
		endcase
	end

endmodule

>>> design/fpq_dp.sv
// ----------------------------------------------------------------------------
// fpq_dp
// Datapath: entry memory, per-level fill counts, and the compacting walk.
// Announce is a remove of the first entry of the highest non-empty level.
// ----------------------------------------------------------------------------
module fpq_dp #(
	parameter int unsigned LEVELS       = fpq_pkg::LEVELS_DEF,
	parameter int unsigned LEVEL_DEPTH  = fpq_pkg::LEVEL_DEPTH_DEF,
	parameter int unsigned SENDER_BITS  = fpq_pkg::SENDER_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = fpq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [fpq_pkg::CMD_BITS-1:0]       command,
	input  logic [fpq_pkg::RANK_BITS-1:0]      rank,
	input  logic [SENDER_BITS-1:0]             sender_id,
	input  logic [PAYLOAD_BITS-1:0]            payload,
	input  fpq_pkg::ctl_t                      ctl,
	output fpq_pkg::sts_t                      sts,
	output logic                               result_valid,
	output logic [fpq_pkg::STATUS_BITS-1:0]    status,
	output logic [fpq_pkg::RANK_BITS-1:0]      out_rank,
	output logic [fpq_pkg::OUT_SENDER_BITS-1:0]  out_sender,
	output logic [fpq_pkg::OUT_PAYLOAD_BITS-1:0] out_payload,
	output logic [fpq_pkg::COUNT_BITS-1:0]     moved_count
);
	import fpq_pkg::*;

	localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int unsigned SW = $clog2(LEVEL_DEPTH);
	localparam int unsigned FW = SW + 1;
	localparam int unsigned AW = LW + SW;
	localparam int unsigned DW = SENDER_BITS + PAYLOAD_BITS;
	localparam int unsigned MEM_DEPTH = LEVELS * (2 ** SW);

	// entry memory, addressed {level, slot}
	logic [DW-1:0] mem [MEM_DEPTH];
	logic [DW-1:0] rd_q;

	logic [FW-1:0] fill_q [LEVELS];

	// latched command
	cmd_t                  cmd_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic [SENDER_BITS-1:0] who_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// walk state
	logic [LW-1:0] lvl_q;
	logic [FW-1:0] rp_q, wp_q;
	logic          found_q;       // announce: entry already taken
	logic [7:0]    total_q;
	status_t       st_q;
	logic [RANK_BITS-1:0] orank_q;
	logic [DW-1:0] oent_q;
	logic          valid_q;

	logic [LW-1:0] up_lvl;
	logic          rank_ok;
	logic [LW-1:0] rank_lvl;
	logic          match, take, lift;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data;
	logic [LW-1:0] top_lvl;

	assign top_lvl  = LW'(LEVELS - 1);
	assign up_lvl   = lvl_q + LW'(1);
	assign rank_ok  = (rank_q != '0) && ({1'b0, rank_q} <= (RANK_BITS+1)'(LEVELS));
	assign rank_lvl = LW'(rank_q - RANK_BITS'(1));

	// status toward controller
	assign sts.is_send    = (cmd_q == CMD_SEND);
	assign sts.level_done = (rp_q == fill_q[lvl_q]);
	assign sts.last_level = (lvl_q == '0) || (cmd_q == CMD_ANNOUNCE && found_q);

	// decision on the entry just read
	assign match = (rd_q[DW-1 -: SENDER_BITS] == who_q);
	assign take  = (cmd_q == CMD_REMOVE && match) ||
	               (cmd_q == CMD_ANNOUNCE && rp_q == '0);
	assign lift  = (cmd_q == CMD_PROMOTE) && match &&
	               (fill_q[up_lvl] < FW'(LEVEL_DEPTH));

	// memory write select
	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = {who_q, pay_q};
		if (ctl.do_send && rank_ok && fill_q[rank_lvl] < FW'(LEVEL_DEPTH)) begin
			wr_en = 1'b1;
			wr_addr = {rank_lvl, fill_q[rank_lvl][SW-1:0]};
		end else if (ctl.scan_step && lift) begin
			wr_en = 1'b1;
			wr_addr = {up_lvl, fill_q[up_lvl][SW-1:0]};
			wr_data = rd_q;
		end else if (ctl.scan_step && !take && !lift) begin
			wr_en = 1'b1;
			wr_addr = {lvl_q, wp_q[SW-1:0]};
			wr_data = rd_q;
		end
	end

	assign rd_addr = {lvl_q, rp_q[SW-1:0]};

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (ctl.scan_rd) rd_q <= mem[rd_addr];
	end

	// command capture and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) fill_q[i] <= '0;
			valid_q <= 1'b0;
			cmd_q <= CMD_SEND;
			rank_q <= '0;
			who_q <= '0;
			pay_q <= '0;
			lvl_q <= '0;
			rp_q <= '0;
			wp_q <= '0;
			found_q <= 1'b0;
			total_q <= '0;
			st_q <= ST_DONE;
			orank_q <= '0;
			oent_q <= '0;
		end else begin
			valid_q <= ctl.finish;
			if (ctl.latch) begin
				cmd_q <= cmd_t'(command);
				rank_q <= rank;
				who_q <= sender_id;
				pay_q <= payload;
			end
			if (ctl.do_send) begin
				if (rank_ok && fill_q[rank_lvl] < FW'(LEVEL_DEPTH)) begin
					fill_q[rank_lvl] <= fill_q[rank_lvl] + FW'(1);
					st_q <= ST_DONE;
				end else begin
					st_q <= ST_DROPPED;
				end
				orank_q <= '0;
				total_q <= '0;
			end
			if (ctl.scan_init) begin
				lvl_q <= (cmd_q == CMD_PROMOTE) ? top_lvl - LW'(1) : top_lvl;
				rp_q <= '0;
				wp_q <= '0;
				found_q <= 1'b0;
				total_q <= '0;
				orank_q <= '0;
				st_q <= (cmd_q == CMD_ANNOUNCE) ? ST_EMPTY : ST_DONE;
			end
			if (ctl.scan_step) begin
				rp_q <= rp_q + FW'(1);
				if (take || lift) begin
					if (cmd_q != CMD_ANNOUNCE && total_q < 8'(COUNT_MAX))
						total_q <= total_q + 8'd1;
				end else begin
					wp_q <= wp_q + FW'(1);
				end
				if (lift) fill_q[up_lvl] <= fill_q[up_lvl] + FW'(1);
				if (cmd_q == CMD_ANNOUNCE && take) begin
					found_q <= 1'b1;
					st_q <= ST_ANNOUNCED;
					orank_q <= RANK_BITS'(lvl_q) + RANK_BITS'(1);
					oent_q <= rd_q;
				end
			end
			// close level: kept entries end at the write pointer
			if (ctl.scan_end) begin
				fill_q[lvl_q] <= wp_q;
			end
			if (ctl.lvl_next) begin
				lvl_q <= lvl_q - LW'(1);
				rp_q <= '0;
				wp_q <= '0;
			end
		end
	end

	// announce takes slot 0, the rest of that level shifts down by one
	// and the walk stops after that level

	assign result_valid = valid_q;
	assign status       = st_q;
	assign out_rank     = orank_q;
	assign out_sender   = (st_q == ST_ANNOUNCED) ?
	                      OUT_SENDER_BITS'(oent_q[DW-1 -: SENDER_BITS]) : '0;
	assign out_payload  = (st_q == ST_ANNOUNCED) ?
	                      OUT_PAYLOAD_BITS'(oent_q[PAYLOAD_BITS-1:0]) : '0;
	assign moved_count  = (total_q > 8'(COUNT_MAX)) ? COUNT_BITS'(COUNT_MAX) :
	                      total_q[COUNT_BITS-1:0];

endmodule

>>> design/five_level_priority_queue_purge_promote_core.sv
// ----------------------------------------------------------------------------
// five_level_priority_queue_purge_promote_core
// Multi-level priority queue with send, announce, purge and promote.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and cannot be held off. Send
// is handled in DECODE and then goes to DONE. Announce, remove and promote
// walk the levels through the single-port entry memory, reading each stored
// entry in READ, handling it in SCAN and moving to the next level in NEXT.
// Announce passes over empty levels from the top down and stops after the
// level it pops from, which it reads and compacts.
module five_level_priority_queue_purge_promote_core #(
	parameter int unsigned LEVELS       = fpq_pkg::LEVELS_DEF,
	parameter int unsigned LEVEL_DEPTH  = fpq_pkg::LEVEL_DEPTH_DEF,
	parameter int unsigned SENDER_BITS  = fpq_pkg::SENDER_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = fpq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [fpq_pkg::CMD_BITS-1:0]         command,
	input  logic [fpq_pkg::RANK_BITS-1:0]        rank,
	input  logic [SENDER_BITS-1:0]               sender_id,
	input  logic [PAYLOAD_BITS-1:0]              payload,
	output logic                                 done,
	output logic [fpq_pkg::STATUS_BITS-1:0]      status,
	output logic [fpq_pkg::RANK_BITS-1:0]        out_rank,
	output logic [fpq_pkg::OUT_SENDER_BITS-1:0]  out_sender,
	output logic [fpq_pkg::OUT_PAYLOAD_BITS-1:0] out_payload,
	output logic [fpq_pkg::COUNT_BITS-1:0]       moved_count
);
	import fpq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer
	fpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// storage and walk
	fpq_dp #(
		.LEVELS       (LEVELS),
		.LEVEL_DEPTH  (LEVEL_DEPTH),
		.SENDER_BITS  (SENDER_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.rank         (rank),
		.sender_id    (sender_id),
		.payload      (payload),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (done),
		.status       (status),
		.out_rank     (out_rank),
		.out_sender   (out_sender),
		.out_payload  (out_payload),
		.moved_count  (moved_count)
	);

endmodule
